// ----- rtl/mi_pkg.sv -----
// Package for the modular inverse unit: sequencer states and the reset modulus constant.
package mi_pkg;

  // Reset modulus, truncated to the datapath width at the use site.
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_UPD,
    S_RED,
    S_NEG,
    S_DONE
  } state_t;

endpackage

// ----- rtl/mi_if.sv -----
// Valid/ready channel interfaces for the modular inverse unit.
interface mi_in_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface mi_out_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] inverse;
  logic [W-1:0] common_divisor;
  logic         no_inverse;

  modport source (output valid, output inverse, output common_divisor, output no_inverse,
                  input ready);
  modport sink   (input valid, input inverse, input common_divisor, input no_inverse,
                  output ready);
endinterface

// ----- rtl/modular_inverse_unit.sv -----
// Modular inverse by the extended Euclidean algorithm, with a radix-2 shared divider.
//
// Each input transaction carries one value; the unit returns one result transaction
// with gcd(value, modulus), the inverse of value modulo modulus (0 when none exists)
// and a no_inverse flag that is set when the gcd is not 1. The modulus is a
// configuration register (reset 1000000007) written through cfg_we/cfg_wdata while
// the unit is idle; the user must keep to this, as the unit does not enforce it. All
// work runs through one restoring shift-subtract divider that yields one quotient
// bit per cycle; while it runs, the Bezout product q*t is built MSB-first in the same
// pass. There is one divider pass for the first reduction of value by the modulus and
// one per Euclid step after it (at most 46 steps for 32-bit operands). A zero modulus
// skips the divider. in_chan.ready is high only while the sequencer is idle; a
// finished result sits in the output register, so the next transaction is accepted
// while that result still waits for out_chan.ready.
module modular_inverse_unit #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  mi_in_if.sink            in_chan,
  mi_out_if.source         out_chan,
  input  logic             cfg_we,
  input  logic [WIDTH-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(WIDTH);

  mi_pkg::state_t state_r, state_nxt;

  logic [WIDTH-1:0] modulus_r;

  // Divider: dividend shift register, divisor, partial remainder, bit counter.
  logic [WIDTH-1:0] dvd_r, dvd_nxt;
  logic [WIDTH-1:0] dsr_r, dsr_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  // q * t1, accumulated one quotient bit at a time.
  logic [WIDTH-1:0] acc_r, acc_nxt;

  // Euclid state: remainders, coefficient magnitudes and their signs.
  logic [WIDTH-1:0] r0_r, r0_nxt;
  logic [WIDTH-1:0] r1_r, r1_nxt;
  logic [WIDTH-1:0] t0_r, t0_nxt;
  logic [WIDTH-1:0] t1_r, t1_nxt;
  logic             neg0_r, neg0_nxt;
  logic             neg1_r, neg1_nxt;
  logic             first_r, first_nxt;   // divider pass is the initial value % modulus
  logic             mzero_r, mzero_nxt;   // modulus was zero for this item

  // Output register.
  logic             ovalid_r, ovalid_nxt;
  logic [WIDTH-1:0] oinv_r, oinv_nxt;
  logic [WIDTH-1:0] ogcd_r, ogcd_nxt;
  logic             onone_r, onone_nxt;

  // Shared subtractor.
  logic [WIDTH:0]   sub_a, sub_b, sub_y;
  logic [WIDTH:0]   rem_sh;
  logic             qbit;
  logic             in_acc;
  logic             out_free;
  logic             div_last;
  logic             res_none;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !ovalid_r || out_chan.ready;
  assign div_last = (cnt_r == CNT_W'(WIDTH - 1));
  assign rem_sh   = {rem_r, dvd_r[WIDTH-1]};
  assign res_none = mzero_r || (r0_r != WIDTH'(1));

  // Operand select for the one subtractor: remainder trial, reduction, negation.
  always_comb begin
    sub_a = rem_sh;
    sub_b = {1'b0, dsr_r};
    case (state_r)
      mi_pkg::S_RED: begin
        sub_a = {1'b0, t0_r};
        sub_b = {1'b0, modulus_r};
      end
      mi_pkg::S_NEG: begin
        sub_a = {1'b0, modulus_r};
        sub_b = {1'b0, t0_r};
      end
      default: begin
        sub_a = rem_sh;
        sub_b = {1'b0, dsr_r};
      end
    endcase
  end

  assign sub_y = sub_a - sub_b;
  assign qbit  = !sub_y[WIDTH];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mi_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (modulus_r == '0) ? mi_pkg::S_DONE : mi_pkg::S_DIV;
        end
      end
      mi_pkg::S_DIV: begin
        if (div_last) begin
          state_nxt = mi_pkg::S_UPD;
        end
      end
      mi_pkg::S_UPD: begin
        // Remainder of this pass is the new r1; zero ends the remainder sequence.
        state_nxt = (rem_r == '0) ? mi_pkg::S_RED : mi_pkg::S_DIV;
      end
      mi_pkg::S_RED: state_nxt = mi_pkg::S_NEG;
      mi_pkg::S_NEG: state_nxt = mi_pkg::S_DONE;
      mi_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = mi_pkg::S_IDLE;
        end
      end
      default: state_nxt = mi_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    in_chan.ready = (state_r == mi_pkg::S_IDLE);

    dvd_nxt   = dvd_r;
    dsr_nxt   = dsr_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    neg0_nxt  = neg0_r;
    neg1_nxt  = neg1_r;
    first_nxt = first_r;
    mzero_nxt = mzero_r;

    ovalid_nxt = ovalid_r && !out_chan.ready;
    oinv_nxt   = oinv_r;
    ogcd_nxt   = ogcd_r;
    onone_nxt  = onone_r;

    unique case (state_r)
      mi_pkg::S_IDLE: begin
        if (in_acc) begin
          dvd_nxt   = in_chan.value;
          dsr_nxt   = modulus_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          acc_nxt   = '0;
          first_nxt = 1'b1;
          mzero_nxt = (modulus_r == '0);
          r0_nxt    = in_chan.value;   // gcd when the modulus is zero
          t0_nxt    = '0;
        end
      end
      mi_pkg::S_DIV: begin
        rem_nxt = qbit ? sub_y[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        dvd_nxt = {dvd_r[WIDTH-2:0], 1'b0};
        acc_nxt = {acc_r[WIDTH-2:0], 1'b0} + (qbit ? t1_r : '0);
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      mi_pkg::S_UPD: begin
        if (first_r) begin
          r0_nxt   = modulus_r;
          t0_nxt   = '0;
          t1_nxt   = WIDTH'(1);
          neg0_nxt = 1'b0;
          neg1_nxt = 1'b0;
        end else begin
          r0_nxt   = r1_r;
          t0_nxt   = t1_r;
          t1_nxt   = t0_r + acc_r;
          neg0_nxt = neg1_r;
          neg1_nxt = !neg1_r;
        end
        r1_nxt    = rem_r;
        first_nxt = 1'b0;
        // Start the next pass: r0_new / r1_new.
        dvd_nxt   = first_r ? modulus_r : r1_r;
        dsr_nxt   = rem_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        acc_nxt   = '0;
      end
      mi_pkg::S_RED: begin
        // t0 never exceeds the modulus, so one subtract does t0 % modulus.
        if (qbit) begin
          t0_nxt = sub_y[WIDTH-1:0];
        end
      end
      mi_pkg::S_NEG: begin
        if (neg0_r && (t0_r != '0)) begin
          t0_nxt = sub_y[WIDTH-1:0];
        end
      end
      mi_pkg::S_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ogcd_nxt   = r0_r;
          onone_nxt  = res_none;
          oinv_nxt   = res_none ? '0 : t0_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mi_pkg::S_IDLE;
      modulus_r <= mi_pkg::MODULUS_RESET[WIDTH-1:0];
      ovalid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r   <= dvd_nxt;
    dsr_r   <= dsr_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    r0_r    <= r0_nxt;
    r1_r    <= r1_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    neg0_r  <= neg0_nxt;
    neg1_r  <= neg1_nxt;
    first_r <= first_nxt;
    mzero_r <= mzero_nxt;
    oinv_r  <= oinv_nxt;
    ogcd_r  <= ogcd_nxt;
    onone_r <= onone_nxt;
  end

  assign out_chan.valid          = ovalid_r;
  assign out_chan.inverse        = oinv_r;
  assign out_chan.common_divisor = ogcd_r;
  assign out_chan.no_inverse     = onone_r;

endmodule

// ----- rtl/mi_checker.sv -----
// Port-level assertions for the modular inverse unit, bound to the top level.
module mi_checker #(
  parameter int WIDTH = 32
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] out_inverse,
  input logic [WIDTH-1:0] out_common_divisor,
  input logic             out_no_inverse
);

  // One item at a time: busy right after an accepted transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  // No inverse means the reported inverse is zero.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_inverse |-> (out_inverse == '0))
    else $error("nonzero inverse flagged as nonexistent");

  // An inverse exists only for gcd 1.
  a_gcd_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_no_inverse |-> (out_common_divisor == WIDTH'(1)))
    else $error("inverse reported with gcd other than one");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inverse)
      && $stable(out_common_divisor) && $stable(out_no_inverse))
    else $error("stalled result changed");

endmodule

bind modular_inverse_unit mi_checker #(.WIDTH(WIDTH)) u_mi_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_inverse        (out_chan.inverse),
  .out_common_divisor (out_chan.common_divisor),
  .out_no_inverse     (out_chan.no_inverse)
);

// ----- dv/inverse_checker.sv -----
// Checker for the modular inverse unit: predicts each result and compares it field by field.
module inverse_checker #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  mi_in_if                 in_chan,
  mi_out_if                out_chan,
  input  logic             cfg_we,
  input  logic [WIDTH-1:0] cfg_wdata,
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    logic [WIDTH-1:0] inverse;
    logic [WIDTH-1:0] common_divisor;
    logic             no_inverse;
  } inv_result_t;

  logic [WIDTH-1:0] modulus_copy;
  inv_result_t      expected_q[$];
  int               error_count = 0;
  int               pending_count = 0;

  assign mismatches = error_count;
  assign pending    = pending_count;

  // Extended Euclid with unsigned coefficient magnitudes and an alternating sign.
  function automatic inv_result_t solve_inverse(input logic [WIDTH-1:0] value,
                                                input logic [WIDTH-1:0] modulus);
    logic [63:0] r_prev, r_cur, r_next;
    logic [63:0] t_prev, t_cur, t_next;
    logic [63:0] quot;
    logic        neg_prev, neg_cur;
    int          step;
    inv_result_t res;
    res = '0;
    if (modulus == '0) begin
      res.common_divisor = value;
      res.no_inverse     = 1'b1;
      return res;
    end
    r_prev   = 64'(modulus);
    r_cur    = 64'(value) % 64'(modulus);
    t_prev   = 64'd0;
    t_cur    = 64'd1;
    neg_prev = 1'b0;
    neg_cur  = 1'b0;
    step     = 0;
    while (step < 2 * WIDTH && r_cur != 64'd0) begin
      quot     = r_prev / r_cur;
      r_next   = r_prev - quot * r_cur;
      t_next   = t_prev + quot * t_cur;
      r_prev   = r_cur;
      r_cur    = r_next;
      t_prev   = t_cur;
      neg_prev = neg_cur;
      t_cur    = t_next;
      neg_cur  = !neg_cur;
      step++;
    end
    res.common_divisor = r_prev[WIDTH-1:0];
    if (r_prev != 64'd1) begin
      res.no_inverse = 1'b1;
      return res;
    end
    t_prev = t_prev % 64'(modulus);
    if (neg_prev && t_prev != 64'd0) t_prev = 64'(modulus) - t_prev;
    res.inverse = t_prev[WIDTH-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [WIDTH-1:0] got,
                                 input logic [WIDTH-1:0] want);
    $display("%0t: mismatch on %s: got 0x%h, expected 0x%h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    inv_result_t want;
    if (!rst_n) begin
      modulus_copy = mi_pkg::MODULUS_RESET[WIDTH-1:0];
      expected_q.delete();
    end else begin
      if (cfg_we) modulus_copy = cfg_wdata;
      if (out_chan.valid && out_chan.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result transaction", out_chan.inverse, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_chan.inverse !== want.inverse)
            report_mismatch("inverse", out_chan.inverse, want.inverse);
          if (out_chan.common_divisor !== want.common_divisor)
            report_mismatch("common_divisor", out_chan.common_divisor, want.common_divisor);
          if (out_chan.no_inverse !== want.no_inverse)
            report_mismatch("no_inverse", WIDTH'(out_chan.no_inverse), WIDTH'(want.no_inverse));
        end
      end
      if (in_chan.valid && in_chan.ready)
        expected_q.insert(expected_q.size(), solve_inverse(in_chan.value, modulus_copy));
    end
    pending_count <= expected_q.size();
  end

endmodule

// ----- dv/tb_modular_inverse_unit.sv -----
// Testbench top for the modular inverse unit: clock, reset, stimulus, idling and verdict.
module tb_modular_inverse_unit;

  localparam int WIDTH         = 32;
  localparam int IDLE_PCT      = 15;     // idle/stall chance per cycle, in percent
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 175;
  localparam int CALM_PHASE    = 3;      // no idling on either side in this phase
  localparam int SETTLE_CYCLES = 4;      // quiet cycles before a modulus write
  // Tail wait, with margin over the worst item.
  localparam int TAIL_CYCLES   = 2000;
  localparam int STALL_LIMIT   = 20000;  // cycles without any transaction

  localparam logic [WIDTH-1:0] RESET_MODULUS = mi_pkg::MODULUS_RESET[WIDTH-1:0];
  // Consecutive Fibonacci numbers give the longest remainder sequence.
  localparam logic [WIDTH-1:0] FIB_46 = 32'd1836311903;
  localparam logic [WIDTH-1:0] FIB_47 = 32'd2971215073;

  // Directed values under the reset modulus: zero, unit, extremes, values at and
  // above the modulus (reduction path) and the inverse of two.
  localparam logic [WIDTH-1:0] RESET_MOD_VALUES [10] = '{
    32'd0, 32'd1, 32'd2, RESET_MODULUS - 32'd1, RESET_MODULUS, RESET_MODULUS + 32'd1,
    RESET_MODULUS * 32'd2, 32'hFFFF_FFFF, 32'h8000_0000, 32'd500000004
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [WIDTH-1:0] cfg_wdata;
  logic [WIDTH-1:0] cur_modulus;
  bit               calm;          // suppresses idling on both sides
  int               stall_cycles = 0;
  int               mismatches;
  int               pending;

  mi_in_if  #(.W(WIDTH)) in_chan ();
  mi_out_if #(.W(WIDTH)) out_chan ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modular_inverse_unit #(.WIDTH(WIDTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  inverse_checker #(.WIDTH(WIDTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Result side back-pressure: random stalls except during the calm phase.
  always @(posedge clk) begin
    out_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: any accepted transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one value, with random idle cycles first, and hold it until accepted.
  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_value(input logic [WIDTH-1:0] value);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.value <= value;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Modulus writes happen only with the unit idle and nothing outstanding.
  task automatic write_modulus(input logic [WIDTH-1:0] modulus);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= modulus;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_modulus  = modulus;
  endtask

  function automatic logic [WIDTH-1:0] phase_modulus(input int phase);
    case (phase)
      0:       return 32'd2;
      1:       return 32'hFFFF_FFFF;           // 3*5*17*257*65537, many shared factors
      2:       return RESET_MODULUS;
      3:       return $urandom | 32'd1;
      4:       return 32'h8000_0000;           // power of two: every even value fails
      5:       return $urandom_range(3, 1000); // most values need the reduction
      6:       return 32'hFFFF_FFFB;           // largest 32-bit prime
      7:       return 32'd1;                   // smallest nonzero modulus
      8:       return 32'd0;                   // zero modulus, divider skipped
      default: return $urandom;
    endcase
  endfunction

  // Value mix: mostly full-range random, plus zero/small values, values around the
  // modulus, multiples of small primes (shared factors) and values near the top.
  function automatic logic [WIDTH-1:0] pick_value(input logic [WIDTH-1:0] modulus);
    logic [WIDTH-1:0] prime;
    case ($urandom_range(0, 3))
      0:       prime = 32'd2;
      1:       prime = 32'd3;
      2:       prime = 32'd5;
      default: prime = 32'd7;
    endcase
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 16);
      1:       return modulus + $urandom_range(0, 4) - 32'd2;
      2:       return $urandom_range(1, 100000) * prime;
      3:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    calm           = 1'b0;
    cur_modulus    = RESET_MODULUS;
    in_chan.valid  = 1'b0;
    in_chan.value  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset modulus first, then the modulus extremes.
    foreach (RESET_MOD_VALUES[i]) send_value(RESET_MOD_VALUES[i]);
    write_modulus(FIB_47);
    send_value(FIB_46);
    send_value(32'd1);
    write_modulus(32'd2);
    send_value(32'd0);
    send_value(32'd3);
    write_modulus(32'hFFFF_FFFF);
    send_value(32'd3);
    send_value(32'hFFFF_FFFE);
    write_modulus(32'd1);
    send_value(32'd5);
    write_modulus(32'd0);
    send_value(32'd12345);
    send_value(32'd0);

    // Random phases, each under its own modulus; each write drains the unit first,
    // so the sender pauses until every outstanding result is back.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_modulus(phase_modulus(phase));
      calm = (phase == CALM_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) send_value(pick_value(cur_modulus));
    end
    calm = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
